// ----- rtl/core/ptd_pkg.sv -----
// ptd_pkg: shared types and constants of the prime test and twin detect block
// depends on nothing; used by the top level and the testbench
`default_nettype none

package ptd_pkg;

  // smallest prime, also the gap of a twin pair
  localparam int unsigned FIRST_PRIME = 2;

  // sequencer states
  typedef enum logic [1:0] {
    S_IDLE,
    S_CHECK,
    S_DIV,
    S_FIN
  } state_t;

endpackage

`default_nettype wire

// ----- rtl/core/ptd_in_if.sv -----
// ptd_in_if: input channel carrying one candidate word
// depends on nothing
`default_nettype none

interface ptd_in_if #(
  parameter int VALUE_BITS = 18
);
  logic                  valid;
  logic                  ready;
  logic [VALUE_BITS-1:0] number;
  logic                  first_of_range;

  modport source (output valid, output number, output first_of_range, input ready);
  modport sink   (input valid, input number, input first_of_range, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/ptd_out_if.sv -----
// ptd_out_if: result channel carrying the prime and twin flags
// depends on nothing
`default_nettype none

interface ptd_out_if #(
  parameter int VALUE_BITS = 18
);
  logic                  valid;
  logic                  ready;
  logic                  is_prime;
  logic                  twin_found;
  logic [VALUE_BITS-1:0] twin_low;

  modport source (output valid, output is_prime, output twin_found, output twin_low,
                  input ready);
  modport sink   (input valid, input is_prime, input twin_found, input twin_low,
                  output ready);
endinterface

`default_nettype wire

// ----- rtl/core/ptd_rem.sv -----
// ptd_rem: shared remainder unit, restoring division one dividend bit per cycle
// depends on nothing; instantiated by prime_test_twin_detect
`default_nettype none

module ptd_rem #(
  parameter int VALUE_BITS = 18,
  parameter int DIV_BITS   = 11
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  start,
  input  wire logic [VALUE_BITS-1:0] dividend,
  input  wire logic [DIV_BITS-1:0]   divisor,
  output logic                       done,
  output logic                       rem_zero
);

  localparam int CW = $clog2(VALUE_BITS + 1);

  logic                  busy;
  logic [CW-1:0]         cnt;
  logic [VALUE_BITS-1:0] sh;
  logic [DIV_BITS-1:0]   dv;
  logic [DIV_BITS-1:0]   r;
  logic [DIV_BITS:0]     trial;
  logic [DIV_BITS:0]     diff;

  // shift in next dividend bit, subtract when it fits
  always_comb begin
    trial = {r, sh[VALUE_BITS-1]};
    diff  = trial - {1'b0, dv};
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(VALUE_BITS);
      end else if (busy) begin
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      sh <= dividend;
      dv <= divisor;
      r  <= '0;
    end else if (busy) begin
      sh <= {sh[VALUE_BITS-2:0], 1'b0};
      if (!diff[DIV_BITS]) begin
        r <= diff[DIV_BITS-1:0];
      end else begin
        r <= trial[DIV_BITS-1:0];
      end
    end
  end

  assign rem_zero = (r == '0);

endmodule

`default_nettype wire

// ----- rtl/core/prime_test_twin_detect.sv -----
// prime_test_twin_detect: trial-division primality test with twin-prime detection
// depends on ptd_pkg, ptd_in_if, ptd_out_if and ptd_rem
//
// usage:
//   in_ch carries one candidate word (number, first_of_range); out_ch returns
//   one word per candidate (is_prime, twin_found, twin_low). first_of_range
//   clears the remembered prime before the candidate is tested.
//   odd divisors d = 3, 5, 7, ... are tried while d*d <= number; the square is
//   kept by a running add, and each n % d runs in the shared remainder unit
//   at one dividend bit per cycle. 0, 1, 2, even numbers and 3..8 are
//   settled without any division; otherwise k divisors are tried, k up to
//   sqrt(number) / 2.
//   in_ch.ready is high only while no candidate is in work; the result sits
//   in an output register, so a new candidate is taken while it waits.
//   if out_ch stalls with a result still held, the next candidate finishes
//   and then waits until the register frees.
//   reset clears the remembered prime, the sequencer and out_ch.valid.
`default_nettype none

module prime_test_twin_detect #(
  parameter int VALUE_BITS = 18
) (
  input wire logic  clk,
  input wire logic  rst,
  ptd_in_if.sink    in_ch,
  ptd_out_if.source out_ch
);

  localparam int DW = (VALUE_BITS + 1) / 2 + 2;
  localparam int SW = 2 * DW;

  ptd_pkg::state_t state, state_next;

  logic [VALUE_BITS-1:0] n;
  logic [VALUE_BITS-1:0] last_prime;
  logic [DW-1:0]         d;
  logic [SW-1:0]         sq;
  logic                  prime;
  logic                  prime_next;

  logic                  rem_start;
  logic                  rem_done;
  logic                  rem_zero;

  logic                  out_valid;
  logic                  out_is_prime;
  logic                  out_twin;
  logic [VALUE_BITS-1:0] out_low;

  logic                  is_small;
  logic                  is_two;
  logic                  root_done;
  logic                  out_free;
  logic                  twin_hit;

  // candidate classification
  always_comb begin
    is_small  = (n < VALUE_BITS'(ptd_pkg::FIRST_PRIME));
    is_two    = (n == VALUE_BITS'(ptd_pkg::FIRST_PRIME));
    root_done = (sq > SW'(n));
    out_free  = !out_valid || out_ch.ready;
    twin_hit  = prime && (last_prime != '0) &&
                ({1'b0, last_prime} + (VALUE_BITS + 1)'(ptd_pkg::FIRST_PRIME) ==
                 {1'b0, n});
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ptd_pkg::S_IDLE: begin
        if (in_ch.valid) state_next = ptd_pkg::S_CHECK;
      end
      ptd_pkg::S_CHECK: begin
        if (is_small || is_two || !n[0] || root_done) begin
          state_next = ptd_pkg::S_FIN;
        end else begin
          state_next = ptd_pkg::S_DIV;
        end
      end
      ptd_pkg::S_DIV: begin
        if (rem_done) begin
          state_next = rem_zero ? ptd_pkg::S_FIN : ptd_pkg::S_CHECK;
        end
      end
      ptd_pkg::S_FIN: begin
        if (out_free) state_next = ptd_pkg::S_IDLE;
      end
      default: state_next = ptd_pkg::S_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_ch.ready = 1'b0;
    rem_start   = 1'b0;
    prime_next  = prime;
    unique case (state)
      ptd_pkg::S_IDLE: in_ch.ready = 1'b1;
      ptd_pkg::S_CHECK: begin
        if (is_small) begin
          prime_next = 1'b0;
        end else if (is_two) begin
          prime_next = 1'b1;
        end else if (!n[0]) begin
          prime_next = 1'b0;
        end else if (root_done) begin
          prime_next = 1'b1;
        end else begin
          rem_start = 1'b1;
        end
      end
      ptd_pkg::S_DIV: begin
        if (rem_done && rem_zero) prime_next = 1'b0;
      end
      ptd_pkg::S_FIN: ;
      default: ;
    endcase
  end

  // state and remembered prime
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ptd_pkg::S_IDLE;
      last_prime <= '0;
    end else begin
      state <= state_next;
      if (state == ptd_pkg::S_IDLE && in_ch.valid && in_ch.first_of_range) begin
        last_prime <= '0;
      end else if (state == ptd_pkg::S_FIN && out_free && prime) begin
        last_prime <= n;
      end
    end
  end

  // candidate, divisor and running square
  always_ff @(posedge clk) begin
    prime <= prime_next;
    if (state == ptd_pkg::S_IDLE && in_ch.valid) begin
      n  <= in_ch.number;
      d  <= DW'(3);
      sq <= SW'(9);
    end else if (state == ptd_pkg::S_DIV && rem_done && !rem_zero) begin
      // (d + 2)^2 = d^2 + 4d + 4
      d  <= d + DW'(2);
      sq <= sq + SW'({d, 2'b00}) + SW'(4);
    end
  end

  // shared remainder unit
  ptd_rem #(
    .VALUE_BITS (VALUE_BITS),
    .DIV_BITS   (DW)
  ) u_rem (
    .clk      (clk),
    .rst      (rst),
    .start    (rem_start),
    .dividend (n),
    .divisor  (d),
    .done     (rem_done),
    .rem_zero (rem_zero)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ptd_pkg::S_FIN && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ptd_pkg::S_FIN && out_free) begin
      out_is_prime <= prime;
      out_twin     <= twin_hit;
      out_low      <= twin_hit ? last_prime : '0;
    end
  end

  assign out_ch.valid      = out_valid;
  assign out_ch.is_prime   = out_is_prime;
  assign out_ch.twin_found = out_twin;
  assign out_ch.twin_low   = out_low;

endmodule

`default_nettype wire

// ----- rtl/core/ptd_checker.sv -----
// ptd_checker: port-level assertions for prime_test_twin_detect, with its bind
// depends on prime_test_twin_detect ports only
`default_nettype none

module ptd_checker #(
  parameter int VALUE_BITS = 18
) (
  input wire logic                  clk,
  input wire logic                  rst,
  input wire logic                  in_valid,
  input wire logic                  in_ready,
  input wire logic                  out_valid,
  input wire logic                  out_ready,
  input wire logic                  is_prime,
  input wire logic                  twin_found,
  input wire logic [VALUE_BITS-1:0] twin_low
);

  // a held result word stays until taken
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(twin_low) && $stable(is_prime))
    else $error("result word changed while stalled");

  // one candidate at a time
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while a candidate is in work");

  // a twin needs a prime
  a_twin_prime: assert property (@(posedge clk) disable iff (rst)
    out_valid && twin_found |-> is_prime)
    else $error("twin flagged on a non-prime");

  // low member is zero unless a twin is flagged
  a_low_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !twin_found |-> twin_low == '0)
    else $error("twin_low set without a twin");

  // a twin's lower member is odd and at least three
  a_low_odd: assert property (@(posedge clk) disable iff (rst)
    out_valid && twin_found |-> twin_low[0] && twin_low != VALUE_BITS'(1))
    else $error("twin_low is not an odd prime");

endmodule

bind prime_test_twin_detect ptd_checker #(
  .VALUE_BITS (VALUE_BITS)
) u_ptd_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .is_prime   (out_ch.is_prime),
  .twin_found (out_ch.twin_found),
  .twin_low   (out_ch.twin_low)
);

`default_nettype wire

// ----- sim/prime_test_twin_detect_tb.sv -----
// prime_test_twin_detect_tb: self-checking bench for the prime test with twin detect
// depends on ptd_pkg, ptd_in_if, ptd_out_if and prime_test_twin_detect
// a scoreboard class predicts each result word; plain tasks drive random handshakes
`timescale 1ns / 1ps

localparam int TB_VALUE_BITS = 18;

typedef logic [TB_VALUE_BITS-1:0] value_t;

typedef struct packed {
  logic   is_prime;
  logic   twin_found;
  value_t twin_low;
} verdict_t;

// tracks the last prime of the current range and queues the expected verdicts
class twin_prime_scoreboard;
  value_t   last_prime;
  verdict_t expected_q[$];
  int       errors;

  function new();
    last_prime = '0;
    errors     = 0;
  endfunction

  // odd divisors up to the square root
  function bit trial_prime(value_t n);
    longint unsigned d;
    if (n < ptd_pkg::FIRST_PRIME) return 1'b0;
    if (n == ptd_pkg::FIRST_PRIME) return 1'b1;
    if (!n[0]) return 1'b0;
    for (d = 3; d * d <= n; d += 2) begin
      if (n % d == 0) return 1'b0;
    end
    return 1'b1;
  endfunction

  // accepted candidate word: work out its verdict and update the memory
  function void note_candidate(value_t n, logic first);
    verdict_t v;
    v = '0;
    if (first) last_prime = '0;
    v.is_prime = trial_prime(n);
    if (v.is_prime) begin
      if (last_prime != 0 && last_prime + ptd_pkg::FIRST_PRIME == n) begin
        v.twin_found = 1'b1;
        v.twin_low   = last_prime;
      end
      last_prime = n;
    end
    expected_q.push_back(v);
  endfunction

  // accepted result word against the oldest expectation
  function void check_verdict(verdict_t got);
    verdict_t want;
    if (expected_q.size() == 0) begin
      $display("%0t: result with nothing expected: prime %0b twin %0b low %0d",
               $time, got.is_prime, got.twin_found, got.twin_low);
      errors++;
      return;
    end
    want = expected_q.pop_front();
    if (got.is_prime !== want.is_prime || got.twin_found !== want.twin_found ||
        got.twin_low !== want.twin_low) begin
      $display("%0t: mismatch: expected %0b/%0b/%0d, got %0b/%0b/%0d (prime/twin/low)",
               $time, want.is_prime, want.twin_found, want.twin_low,
               got.is_prime, got.twin_found, got.twin_low);
      errors++;
    end
  endfunction

  function int pending();
    return expected_q.size();
  endfunction
endclass

module prime_test_twin_detect_tb;

  localparam int          CYCLE_LIMIT    = 4_000_000;
  localparam int          RANDOM_ITEMS   = 117;
  localparam int          HOLD_AT        = 40;
  localparam int          HOLD_CYCLES    = 6000;
  localparam int          TAIL_CYCLES    = 300;
  localparam int unsigned MAX_VALUE      = (1 << TB_VALUE_BITS) - 1;
  localparam int          DIRECTED_COUNT = 23;

  logic clk;
  logic rst;
  int   results_seen = 0;
  bit   sender_burst = 1'b0;

  twin_prime_scoreboard primes_sb = new();

  // directed words: small primes and twins, squares, range markers, descending pair, top values
  int unsigned directed_values [DIRECTED_COUNT] = '{
    0, 1, 2, 3, 4, 5, 7, 9, 11, 13, 25, 29, 31, 41, 43, 47, 19, 17, 49,
    250000, 262139, 262141, 262143
  };
  bit directed_marks [DIRECTED_COUNT] = '{
    1, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1, 1, 0, 0, 0, 0,
    1, 0, 0, 0
  };

  ptd_in_if  #(.VALUE_BITS(TB_VALUE_BITS)) in_ch ();
  ptd_out_if #(.VALUE_BITS(TB_VALUE_BITS)) out_ch ();

  prime_test_twin_detect #(
    .VALUE_BITS(TB_VALUE_BITS)
  ) i_dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // gap after an accepted word: mostly none, some short, a few long
  function automatic int sender_gap();
    int r;
    if (sender_burst) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 4);
    return $urandom_range(20, 120);
  endfunction

  // offer one candidate word and hold it until taken
  task automatic send_word(input value_t n, input logic first);
    int gap;
    in_ch.valid          <= 1'b1;
    in_ch.number         <= n;
    in_ch.first_of_range <= first;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    primes_sb.note_candidate(n, first);
    gap = sender_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // ascending runs with random content, a few high runs, plus stray words
  task automatic send_random_runs(input int target);
    int          sent;
    int          run_len;
    int          k;
    int          step;
    int unsigned cand;
    logic        first;
    bit          high_run;
    bit          odd_walk;
    sent = 0;
    while (sent < target) begin
      sender_burst = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 9) == 0) begin
        // stray word anywhere, out of order
        if ($urandom_range(0, 1) == 1) cand = $urandom & MAX_VALUE;
        else cand = $urandom_range(0, 4095);
        send_word(value_t'(cand), logic'($urandom_range(0, 1)));
        sent++;
      end else begin
        high_run = ($urandom_range(0, 5) == 0);
        odd_walk = ($urandom_range(0, 1) == 1);
        run_len  = high_run ? $urandom_range(3, 8) : $urandom_range(4, 14);
        cand     = high_run ? $urandom_range(200000, 262100) : $urandom_range(0, 3000);
        if (odd_walk) cand = cand | 1;
        first = ($urandom_range(0, 7) != 0);
        for (k = 0; k < run_len && sent < target && cand <= MAX_VALUE; k++) begin
          send_word(value_t'(cand), first);
          sent++;
          // rare marker inside a run
          first = ($urandom_range(0, 19) == 0);
          step  = odd_walk ? 2 : $urandom_range(1, 6);
          // now and then step back to break the order
          if ($urandom_range(0, 24) == 0 && cand > 10) cand = cand - $urandom_range(1, 10);
          else cand = cand + step;
        end
      end
    end
    sender_burst = 1'b0;
  endtask

  // result side: random ready, long stalls, one long hold to back the block up
  initial begin
    verdict_t got;
    int       hold_left;
    int       stall_left;
    int       mode_left;
    bit       hold_done;
    bit       eager;
    hold_left  = 0;
    stall_left = 0;
    mode_left  = 0;
    hold_done  = 1'b0;
    eager      = 1'b0;
    out_ch.ready <= 1'b0;
    wait (rst === 1'b0);
    forever begin
      @(posedge clk);
      if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
        got = {out_ch.is_prime, out_ch.twin_found, out_ch.twin_low};
        primes_sb.check_verdict(got);
        results_seen++;
      end
      if (!hold_done && results_seen >= HOLD_AT) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (mode_left == 0) begin
        eager     = ($urandom_range(0, 2) == 0);
        mode_left = $urandom_range(50, 400);
      end else begin
        mode_left--;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else if (eager) begin
        out_ch.ready <= 1'b1;
      end else if ($urandom_range(0, 49) == 0) begin
        stall_left = $urandom_range(20, 150);
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(0, 3) != 0);
      end
    end
  end

  // watchdog
  initial begin
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("prime_test_twin_detect_tb: errors");
    $finish;
  end

  // reset, directed words, random runs, drain
  initial begin
    int i;
    rst                  <= 1'b1;
    in_ch.valid          <= 1'b0;
    in_ch.number         <= '0;
    in_ch.first_of_range <= 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    for (i = 0; i < DIRECTED_COUNT; i++) begin
      send_word(value_t'(directed_values[i]), directed_marks[i]);
    end
    send_random_runs(RANDOM_ITEMS);
    in_ch.valid <= 1'b0;
    while (primes_sb.pending() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (primes_sb.errors == 0) begin
      $display("prime_test_twin_detect_tb: clean");
    end else begin
      $display("prime_test_twin_detect_tb: errors");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/core/ptd_pkg.sv
rtl/core/ptd_in_if.sv
rtl/core/ptd_out_if.sv
rtl/core/ptd_rem.sv
rtl/core/prime_test_twin_detect.sv
rtl/core/ptd_checker.sv
sim/prime_test_twin_detect_tb.sv
